/* hw/rtl/cpmf_pkg.sv */
package cpmf_pkg;

	localparam int unsigned COUNT_W = 11;
	localparam int unsigned COL_W = 12;
	localparam int unsigned DIFF_W = 14;
	localparam int unsigned GRAY_W = 8;
	localparam int unsigned WIN_LEN = 7;
	localparam int unsigned FIRST_EVAL_COL = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COL_W-1:0] COLUMN_MAX = '1;

	// APB register map
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic [ADDR_W-3:0] REG_ON_VALUE = '0;

	// Result kinds
	localparam logic KIND_MINIMUM = 1'b0;
	localparam logic KIND_END = 1'b1;

	// Output queue
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic kind;
		logic [COL_W-1:0] index;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t item0;
		result_t item1;
	} push_t;

	typedef struct packed {
		logic room2;
		logic [QCNT_W-1:0] count;
	} qstatus_t;

endpackage

/* hw/rtl/column_profile_minima_finder.sv */
// Column profile minima finder. Gray pixels enter one item per cycle in column-major order
// (top to bottom, then left to right); each pixel equal to the on_value register adds one
// to the count of its column, saturating at 2047. When column c (c >= 7) completes, column
// c-3 is judged from a weighted difference of the eight counts around it, and a local
// minimum is reported as a result item of kind 0 with its column index; the final pixel of
// an image also yields an end marker of kind 1 and clears all column state. An input item
// is taken into an input register and processed there when the queue has room, so the block
// sustains one pixel per cycle; it holds in_ready low only when its four-entry output queue
// has fewer than two free places, which can happen only when the consumer stalls.
module column_profile_minima_finder (
	input logic clk,
	input logic arst_n,
	// APB configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [cpmf_pkg::ADDR_W-1:0] paddr,
	input logic [cpmf_pkg::DATA_W-1:0] pwdata,
	output logic [cpmf_pkg::DATA_W-1:0] prdata,
	output logic pready,
	// Pixel input channel
	input logic in_valid,
	output logic in_ready,
	input logic [cpmf_pkg::GRAY_W-1:0] pixel_gray,
	input logic last_in_column,
	input logic last_in_image,
	// Result output channel
	output logic out_valid,
	input logic out_ready,
	output logic result_kind,
	output logic [cpmf_pkg::COL_W-1:0] column_index
);

	// Configuration register. The user must write it only while the block is idle; the block does not enforce this.
	logic [cpmf_pkg::GRAY_W-1:0] on_value_q;
	logic reg_sel;

	assign pready = 1'b1;
	assign reg_sel = (paddr[cpmf_pkg::ADDR_W-1:2] == cpmf_pkg::REG_ON_VALUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_value_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			on_value_q <= pwdata[cpmf_pkg::GRAY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[cpmf_pkg::GRAY_W-1:0] = on_value_q;
		end
	end

	// Input register stage.
	logic valid_s1;
	logic [cpmf_pkg::GRAY_W-1:0] gray_s1;
	logic col_end_s1;
	logic img_end_s1;
	logic go_s1;
	cpmf_pkg::qstatus_t qstatus;

	// The stage moves on whenever the output queue can absorb the two results an item may cause.
	assign go_s1 = valid_s1 && qstatus.room2;
	assign in_ready = !valid_s1 || qstatus.room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			gray_s1 <= pixel_gray;
			col_end_s1 <= last_in_column;
			img_end_s1 <= last_in_image;
		end
	end

	// Column state.
	logic [cpmf_pkg::COUNT_W-1:0] col_count_q;
	logic [cpmf_pkg::COUNT_W-1:0] win_q [cpmf_pkg::WIN_LEN];
	logic signed [cpmf_pkg::DIFF_W-1:0] prev_diff_q;
	logic seen_descent_q;
	logic [cpmf_pkg::COL_W-1:0] cur_col_q;

	logic [cpmf_pkg::COUNT_W-1:0] newest;
	logic col_done;
	logic do_eval;
	logic [cpmf_pkg::DIFF_W-1:0] left_sum;
	logic [cpmf_pkg::DIFF_W-1:0] right_sum;
	logic signed [cpmf_pkg::DIFF_W:0] diff_full;
	logic signed [cpmf_pkg::DIFF_W-1:0] diff;
	logic signed [cpmf_pkg::DIFF_W:0] neg_diff;
	logic [cpmf_pkg::COL_W-1:0] eval_col;
	logic found;
	logic [cpmf_pkg::COL_W-1:0] found_col;
	cpmf_pkg::push_t push;

	// The count of the current column including this pixel.
	assign newest = ((gray_s1 == on_value_q) && (col_count_q != cpmf_pkg::COUNT_MAX)) ?
		col_count_q + 1'b1 : col_count_q;

	// An image end also closes the column it falls in.
	assign col_done = col_end_s1 || img_end_s1;
	assign do_eval = col_done && (cur_col_q >= cpmf_pkg::COL_W'(cpmf_pkg::FIRST_EVAL_COL));

	// Weighted difference: the four older counts, the one just left of the candidate doubled,
	// minus the candidate doubled and the three newer counts. Each side is at most five times
	// 2047, so both fit in the difference width unsigned and their difference in one bit more.
	assign left_sum = cpmf_pkg::DIFF_W'(win_q[0]) + cpmf_pkg::DIFF_W'(win_q[1])
		+ cpmf_pkg::DIFF_W'(win_q[2]) + cpmf_pkg::DIFF_W'({win_q[3], 1'b0});
	assign right_sum = cpmf_pkg::DIFF_W'({win_q[4], 1'b0}) + cpmf_pkg::DIFF_W'(win_q[5])
		+ cpmf_pkg::DIFF_W'(win_q[6]) + cpmf_pkg::DIFF_W'(newest);
	assign diff_full = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});

	// Clamp into the stored difference range.
	always_comb begin
		if (diff_full > $signed((cpmf_pkg::DIFF_W+1)'(2 ** (cpmf_pkg::DIFF_W - 1) - 1))) begin
			diff = {1'b0, {(cpmf_pkg::DIFF_W-1){1'b1}}};
		end else if (diff_full < -$signed((cpmf_pkg::DIFF_W+1)'(2 ** (cpmf_pkg::DIFF_W - 1)))) begin
			diff = {1'b1, {(cpmf_pkg::DIFF_W-1){1'b0}}};
		end else begin
			diff = diff_full[cpmf_pkg::DIFF_W-1:0];
		end
	end

	assign neg_diff = -$signed({diff[cpmf_pkg::DIFF_W-1], diff});
	assign eval_col = cur_col_q - cpmf_pkg::COL_W'(3);

	// A flat step after a descent marks the candidate itself; a turn from a positive difference to
	// a negative one picks whichever neighbour sits nearer to the zero crossing.
	always_comb begin
		found = 1'b0;
		found_col = eval_col;
		if (do_eval) begin
			if ((diff == '0) && seen_descent_q) begin
				found = 1'b1;
			end else if ((prev_diff_q > 0) && (diff < 0)) begin
				found = 1'b1;
				if ($signed({prev_diff_q[cpmf_pkg::DIFF_W-1], prev_diff_q}) < neg_diff) begin
					found_col = eval_col - 1'b1;
				end
			end
		end
	end

	// Results go to the queue minimum first, end marker second.
	always_comb begin
		push.n = 2'd0;
		push.item0.kind = cpmf_pkg::KIND_MINIMUM;
		push.item0.index = found_col;
		push.item1.kind = cpmf_pkg::KIND_END;
		push.item1.index = '0;
		if (go_s1) begin
			if (found && img_end_s1) begin
				push.n = 2'd2;
			end else if (found) begin
				push.n = 2'd1;
			end else if (img_end_s1) begin
				push.n = 2'd1;
				push.item0.kind = cpmf_pkg::KIND_END;
				push.item0.index = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			for (int k = 0; k < cpmf_pkg::WIN_LEN; k++) begin
				win_q[k] <= '0;
			end
			prev_diff_q <= '0;
			seen_descent_q <= 1'b0;
			cur_col_q <= '0;
		end else if (go_s1) begin
			if (img_end_s1) begin
				col_count_q <= '0;
				for (int k = 0; k < cpmf_pkg::WIN_LEN; k++) begin
					win_q[k] <= '0;
				end
				prev_diff_q <= '0;
				seen_descent_q <= 1'b0;
				cur_col_q <= '0;
			end else if (col_end_s1) begin
				col_count_q <= '0;
				for (int k = 0; k < cpmf_pkg::WIN_LEN - 1; k++) begin
					win_q[k] <= win_q[k+1];
				end
				win_q[cpmf_pkg::WIN_LEN-1] <= newest;
				if (cur_col_q != cpmf_pkg::COLUMN_MAX) begin
					cur_col_q <= cur_col_q + 1'b1;
				end
				if (do_eval) begin
					prev_diff_q <= diff;
					if (diff < 0) begin
						seen_descent_q <= 1'b1;
					end
				end
			end else begin
				col_count_q <= newest;
			end
		end
	end

	// Output queue.
	cpmf_pkg::result_t head;

	cpmf_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.status(qstatus),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	assign result_kind = head.kind;
	assign column_index = head.index;

`ifndef SYNTHESIS
	// The queue never holds more items than it has places.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstatus.count <= cpmf_pkg::QCNT_W'(cpmf_pkg::QDEPTH))
		else $error("output queue overflow");

	// A processed image end leaves the column state cleared.
	a_image_clear: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && img_end_s1 |=> (cur_col_q == '0) && (col_count_q == '0) && !seen_descent_q)
		else $error("column state not cleared after image end");

	// When two results are pushed the second is always the end marker.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (push.item0.kind == cpmf_pkg::KIND_MINIMUM)
			&& (push.item1.kind == cpmf_pkg::KIND_END))
		else $error("result pair out of order");
`endif

endmodule

/* hw/rtl/cpmf_out_fifo.sv */
module cpmf_out_fifo (
	input logic clk,
	input logic arst_n,
	input cpmf_pkg::push_t push,
	output cpmf_pkg::qstatus_t status,
	output logic out_valid,
	input logic out_ready,
	output cpmf_pkg::result_t head
);

	cpmf_pkg::result_t mem_q [cpmf_pkg::QDEPTH];
	logic [cpmf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [cpmf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [cpmf_pkg::QCNT_W-1:0] count_q;
	logic pop;
	logic [cpmf_pkg::QPTR_W-1:0] wr_ptr_next1;

	assign pop = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign wr_ptr_next1 = wr_ptr_q + 1'b1;
	assign status.count = count_q;
	assign status.room2 = (count_q <= cpmf_pkg::QCNT_W'(cpmf_pkg::QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_next1] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cpmf_pkg::QPTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + cpmf_pkg::QCNT_W'(push.n) - cpmf_pkg::QCNT_W'(pop);
		end
	end

endmodule

/* tb/tb_column_profile_minima_finder.sv */
// Self-checking testbench for the column profile minima finder.
//
// Pixel items are queued by the sequencing initial block and handed to the block by a
// driver that works on the falling clock edge. A monitor on the rising edge sees every
// handshake. For each accepted pixel item it runs a cycle-free predictor of the column
// counts and the weighted difference, and that predictor appends the expected result
// items to a queue. Each result item that leaves the block is compared field by field
// with the oldest expectation.
//
// The run has four phases. Each phase has its own on_value and its own handshake regime:
// no idling, a sender that idles, a receiver that stalls, and both at once. The register
// is written over APB only when the block is drained. It is then read back.
module tb_column_profile_minima_finder;

	localparam int unsigned DRAIN_CYCLES = 12;	// input register, queue and some margin
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned RANDOM_ITEMS_PER_PHASE = 150;
	localparam int unsigned TINY_IMAGES = 60;
	localparam int signed SLOPE_MAX = 8191;
	localparam int signed SLOPE_MIN = -8192;

	typedef struct {
		logic [cpmf_pkg::GRAY_W-1:0] gray;
		logic col_end;
		logic img_end;
	} pixel_item_t;

	// Clock, reset and every block input start at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [cpmf_pkg::ADDR_W-1:0] paddr = '0;
	logic [cpmf_pkg::DATA_W-1:0] pwdata = '0;
	logic [cpmf_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [cpmf_pkg::GRAY_W-1:0] pixel_gray = '0;
	logic last_in_column = 1'b0;
	logic last_in_image = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic [cpmf_pkg::COL_W-1:0] column_index;

	column_profile_minima_finder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_gray(pixel_gray),
		.last_in_column(last_in_column),
		.last_in_image(last_in_image),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.column_index(column_index)
	);

	always #5 clk = ~clk;

	// Handshake regime, set by the sequencing block for each phase.
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned hold_requests = 0;

	// Pending pixel items and the bookkeeping of the run.
	pixel_item_t pending_pixels[$];
	cpmf_pkg::result_t expected_results[$];
	int unsigned items_left = 0;
	int unsigned items_queued = 0;
	int unsigned pixels_accepted = 0;
	int unsigned minima_seen = 0;
	int unsigned markers_seen = 0;
	int unsigned mismatches = 0;
	bit in_taken = 1'b0;

	// The predictor keeps its own copy of the register and of the column state.
	logic [cpmf_pkg::GRAY_W-1:0] ink_level = '0;
	logic [cpmf_pkg::COUNT_W-1:0] ink_count = '0;
	logic [cpmf_pkg::COUNT_W-1:0] col_hist[cpmf_pkg::WIN_LEN];
	logic signed [cpmf_pkg::DIFF_W-1:0] last_slope = '0;
	bit descent_seen = 1'b0;
	logic [cpmf_pkg::COL_W-1:0] col_pos = '0;

	function automatic void clear_profile();
		ink_count = '0;
		foreach (col_hist[k])
			col_hist[k] = '0;
		last_slope = '0;
		descent_seen = 1'b0;
		col_pos = '0;
	endfunction

	function automatic void push_expected(logic kind, logic [cpmf_pkg::COL_W-1:0] index);
		cpmf_pkg::result_t r;
		r.kind = kind;
		r.index = index;
		expected_results.push_back(r);
	endfunction

	// Works out the result items that one accepted pixel item causes, and advances the state.
	function automatic void predict_pixel(logic [cpmf_pkg::GRAY_W-1:0] gray, logic col_end,
		logic img_end);
		int left;
		int right;
		int slope;
		logic [cpmf_pkg::COL_W-1:0] centre;
		if (gray == ink_level && ink_count != cpmf_pkg::COUNT_MAX)
			ink_count++;
		if (col_end || img_end) begin
			if (col_pos >= cpmf_pkg::FIRST_EVAL_COL) begin
				// The window holds the seven columns before the one that has just ended. Together
				// with that column it spans the centre three columns back, four before it and three after.
				left = int'(col_hist[0]) + int'(col_hist[1]) + int'(col_hist[2])
					+ 2 * int'(col_hist[3]);
				right = 2 * int'(col_hist[4]) + int'(col_hist[5]) + int'(col_hist[6])
					+ int'(ink_count);
				slope = left - right;
				if (slope > SLOPE_MAX)
					slope = SLOPE_MAX;
				if (slope < SLOPE_MIN)
					slope = SLOPE_MIN;
				centre = col_pos - 12'd3;
				if (slope == 0 && descent_seen) begin
					push_expected(cpmf_pkg::KIND_MINIMUM, centre);
				end else if (last_slope > 0 && slope < 0) begin
					// The minimum lies on whichever side of the crossing has the smaller magnitude.
					push_expected(cpmf_pkg::KIND_MINIMUM,
						(last_slope < -slope) ? centre - 12'd1 : centre);
				end
				if (slope < 0)
					descent_seen = 1'b1;
				last_slope = cpmf_pkg::DIFF_W'(slope);
			end
			for (int k = 0; k < cpmf_pkg::WIN_LEN - 1; k++)
				col_hist[k] = col_hist[k + 1];
			col_hist[cpmf_pkg::WIN_LEN - 1] = ink_count;
			ink_count = '0;
			if (col_pos != cpmf_pkg::COLUMN_MAX)
				col_pos++;
		end
		if (img_end) begin
			push_expected(cpmf_pkg::KIND_END, '0);
			clear_profile();
		end
	endfunction

	function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	// The monitor sees both handshakes at the rising edge. Input acceptance feeds the predictor.
	// Output acceptance is checked against the oldest expectation.
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				items_left--;
				pixels_accepted++;
				predict_pixel(pixel_gray, last_in_column, last_in_image);
			end
			if (out_valid && out_ready) begin
				if (result_kind == cpmf_pkg::KIND_END)
					markers_seen++;
				else
					minima_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result item with none outstanding: kind %0d, column %0d",
							result_kind, column_index);
				end else begin
					cpmf_pkg::result_t want;
					want = expected_results.pop_front();
					if (result_kind !== want.kind)
						note_mismatch("result_kind", want.kind, result_kind);
					if (column_index !== want.index)
						note_mismatch("column_index", want.index, column_index);
				end
			end
		end
	end

	// The driver moves to the next pixel item once the current one has been taken. It may also
	// leave the channel idle at random. Valid is never withdrawn before acceptance.
	always @(negedge clk) begin
		pixel_item_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				nxt = pending_pixels.pop_front();
				in_valid <= 1'b1;
				pixel_gray <= nxt.gray;
				last_in_column <= nxt.col_end;
				last_in_image <= nxt.img_end;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random. When asked, it also holds off for a long stretch. That
	// fills the output queue of the block, so the block has to stop taking pixel items.
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic push_pixel(logic [cpmf_pkg::GRAY_W-1:0] gray, logic col_end, logic img_end);
		pixel_item_t it;
		it.gray = gray;
		it.col_end = col_end;
		it.img_end = img_end;
		pending_pixels.push_back(it);
		items_left++;
		items_queued++;
	endtask

	// Pushes one column of identical pixels. The image can end with it.
	task automatic push_column(int unsigned height, logic [cpmf_pkg::GRAY_W-1:0] gray,
		bit ends_image);
		for (int unsigned r = 0; r < height; r++)
			push_pixel(gray, r == height - 1, ends_image && r == height - 1);
	endtask

	// Pushes one well-formed image. Each column has its own height and its own share of ink
	// pixels, so the profile rises and falls at random.
	task automatic push_random_image(int unsigned width, int unsigned max_height);
		int unsigned height;
		int unsigned ink_pct;
		bit ink;
		for (int unsigned c = 0; c < width; c++) begin
			height = $urandom_range(max_height, 1);
			ink_pct = $urandom_range(100, 0);
			for (int unsigned r = 0; r < height; r++) begin
				ink = ($urandom_range(99) < ink_pct);
				push_pixel(ink ? ink_level : cpmf_pkg::GRAY_W'($urandom), r == height - 1,
					c == width - 1 && r == height - 1);
			end
		end
	endtask

	// Mostly well-formed images, some of them narrower than the evaluation window. The rest
	// are loose pixel items with random end flags.
	task automatic push_random_stream(int unsigned target);
		int unsigned start;
		start = items_queued;
		while (items_queued - start < target) begin
			if ($urandom_range(99) < 85) begin
				push_random_image(($urandom_range(99) < 15) ? $urandom_range(7, 1)
					: $urandom_range(30, 8), $urandom_range(4, 1));
			end else begin
				repeat ($urandom_range(4, 1))
					push_pixel(cpmf_pkg::GRAY_W'($urandom), $urandom_range(3, 0) == 0,
						$urandom_range(7, 0) == 0);
			end
		end
	endtask

	// Waits until every pixel item has been taken and every expected result has arrived. It
	// then lets the pipeline settle, because trailing pixel items may cause no result.
	task automatic wait_until_drained();
		while (items_left != 0 || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// APB write of on_value, followed by a read-back. pready is always high, so each transfer
	// is a setup phase followed by an access phase.
	task automatic write_on_value(logic [cpmf_pkg::GRAY_W-1:0] value);
		logic [cpmf_pkg::DATA_W-1:0] got;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {cpmf_pkg::REG_ON_VALUE, 2'b00};
		pwdata = cpmf_pkg::DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (got[cpmf_pkg::GRAY_W-1:0] !== value)
			note_mismatch("on_value read-back", value, got[cpmf_pkg::GRAY_W-1:0]);
		ink_level = value;
	endtask

	logic [cpmf_pkg::GRAY_W-1:0] phase_level[4];
	int unsigned phase_idle[4] = '{0, 55, 0, 28};
	int unsigned phase_stall[4] = '{0, 0, 55, 28};

	initial begin
		logic [11:0] shape;
		clear_profile();
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Both extremes of the register first, then two arbitrary levels.
		phase_level[0] = 8'd255;
		phase_level[1] = 8'd0;
		phase_level[2] = cpmf_pkg::GRAY_W'($urandom_range(254, 1));
		phase_level[3] = cpmf_pkg::GRAY_W'($urandom_range(254, 1));

		for (int p = 0; p < 4; p++) begin
			if (p != 0)
				wait_until_drained();
			write_on_value(phase_level[p]);
			sender_idle_pct = phase_idle[p];
			receiver_stall_pct = phase_stall[p];

			if (p == 0) begin
				// A one-pixel image of the brightest grey: too narrow for anything but the marker.
				push_pixel(8'd255, 1'b1, 1'b1);
				// An image whose end also closes its last column. That column has no end flag.
				push_pixel(8'd0, 1'b0, 1'b0);
				push_pixel(8'd255, 1'b1, 1'b0);
				push_pixel(8'd128, 1'b0, 1'b1);
				// A short profile with a dip, one pixel per column.
				shape = 12'b111110001111;
				for (int c = 11; c >= 0; c--)
					push_column(1, shape[c] ? 8'd255 : 8'd0, c == 0);
			end

			if (p == 2) begin
				// A long hold-off on the result side while one-pixel images keep coming. Each of
				// them produces an end marker, so the output queue fills and the input stalls.
				hold_requests++;
				repeat (TINY_IMAGES)
					push_pixel(cpmf_pkg::GRAY_W'($urandom), 1'b1, 1'b1);
			end

			push_random_stream(RANDOM_ITEMS_PER_PHASE);
		end

		wait_until_drained();
		$display("Sent %0d pixel items in four handshake regimes with on_value %0d, %0d, %0d, %0d.",
			pixels_accepted, phase_level[0], phase_level[1], phase_level[2], phase_level[3]);
		$display("Checked %0d minima and %0d end markers; %0d mismatches.",
			minima_seen, markers_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// A correct run takes well under a tenth of this time.
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/cpmf_pkg.sv
hw/rtl/cpmf_out_fifo.sv
hw/rtl/column_profile_minima_finder.sv
tb/tb_column_profile_minima_finder.sv
